// ===== hw/rtl/lmgf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmgf_pkg
// Shared types, constants and font table for the LED matrix frame buffer.
// ----------------------------------------------------------------------------
package lmgf_pkg;

   localparam int FRAME_WIDTH  = 24;
   localparam int FRAME_HEIGHT = 8;
   localparam int PANEL_SIDE   = 8;

   localparam int PER_PANEL   = PANEL_SIDE * FRAME_HEIGHT;
   localparam int FRAME_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int X_W         = $clog2(FRAME_WIDTH);
   localparam int Y_W         = $clog2(FRAME_HEIGHT);

   localparam int COLOR_W  = 24;
   localparam int INDEX_W  = 8;
   localparam int STEP_W   = 6;
   localparam int BASEX_W  = 9;
   localparam int BASEY_W  = 8;
   localparam int SUMX_W   = BASEX_W + 1;
   localparam int SUMY_W   = BASEY_W + 1;

   localparam int GLYPH_COLS = 3;
   localparam int FONT_ROWS  = 5;
   localparam int ROW_W      = $clog2(FONT_ROWS);

   localparam logic [2:0] OP_SET   = 3'd0;
   localparam logic [2:0] OP_GLYPH = 3'd1;
   localparam logic [2:0] OP_HLINE = 3'd2;
   localparam logic [2:0] OP_VLINE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [5:0]         pos_x;
      logic [3:0]         pos_y;
      logic [5:0]         line_length;
      logic [3:0]         glyph_code;
      logic [COLOR_W-1:0] paint_color;
      logic [INDEX_W-1:0] chain_index;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] read_color;
      logic [INDEX_W-1:0] read_position;
   } rsp_type;

   typedef struct packed {
      logic [BASEX_W-1:0] base_x;
      logic [STEP_W-1:0]  off_x;
      logic [BASEY_W-1:0] base_y;
      logic [STEP_W-1:0]  off_y;
   } addr_op_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] addr;
   } addr_res_type;

   typedef struct packed {
      logic               we;
      logic               rd;
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic               load;
      logic               hit;
      logic [INDEX_W-1:0] position;
   } rsp_ctl_type;

   function automatic logic [FONT_ROWS-1:0] glyph_column(input logic [3:0] code,
                                                         input logic [1:0] col);
      logic [3*FONT_ROWS-1:0] cols;
      unique case (code)
         4'd1:    cols = {5'h1F, 5'h00, 5'h00};
         4'd2:    cols = {5'h17, 5'h15, 5'h1D};
         4'd3:    cols = {5'h1F, 5'h15, 5'h15};
         4'd4:    cols = {5'h1F, 5'h04, 5'h07};
         4'd5:    cols = {5'h1D, 5'h15, 5'h17};
         4'd6:    cols = {5'h1D, 5'h15, 5'h1F};
         4'd7:    cols = {5'h1F, 5'h01, 5'h01};
         4'd8:    cols = {5'h1F, 5'h15, 5'h1F};
         4'd9:    cols = {5'h1F, 5'h15, 5'h17};
         4'd10:   cols = {5'h00, 5'h0A, 5'h00};
         4'd11:   cols = {5'h00, 5'h04, 5'h00};
         default: cols = {5'h1F, 5'h11, 5'h1F};
      endcase
      unique case (col)
         2'd0:    return cols[FONT_ROWS-1:0];
         2'd1:    return cols[2*FONT_ROWS-1:FONT_ROWS];
         default: return cols[3*FONT_ROWS-1:2*FONT_ROWS];
      endcase
   endfunction

endpackage

// ===== hw/rtl/lmgf_addr.sv =====
// ----------------------------------------------------------------------------
// lmgf_addr
// Shared coordinate unit: adds offsets, clips to the frame, forms address.
// ----------------------------------------------------------------------------
module lmgf_addr (
   input  lmgf_pkg::addr_op_type  op,
   output lmgf_pkg::addr_res_type res
);
   import lmgf_pkg::*;

   logic [SUMX_W-1:0] sum_x;
   logic [SUMY_W-1:0] sum_y;

   assign sum_x = SUMX_W'(op.base_x) + SUMX_W'(op.off_x);
   assign sum_y = SUMY_W'(op.base_y) + SUMY_W'(op.off_y);

   assign res.hit  = (sum_x < SUMX_W'(FRAME_WIDTH)) && (sum_y < SUMY_W'(FRAME_HEIGHT));
   assign res.addr = ADDR_W'(sum_y[Y_W-1:0]) * ADDR_W'(FRAME_WIDTH)
                     + ADDR_W'(sum_x[X_W-1:0]);

endmodule

// ===== hw/rtl/lmgf_store.sv =====
// ----------------------------------------------------------------------------
// lmgf_store
// Frame memory, one write or one read per cycle, registered read data.
// Per-entry valid bits make unwritten pixels read as dark after reset.
// ----------------------------------------------------------------------------
module lmgf_store (
   input  logic                                clock,
   input  logic                                reset,
   input  lmgf_pkg::mem_cmd_type               cmd,
   output logic [lmgf_pkg::COLOR_W-1:0]        rdata
);
   import lmgf_pkg::*;

   logic [COLOR_W-1:0]     mem [FRAME_DEPTH];
   logic [FRAME_DEPTH-1:0] valid_ff;
   logic [COLOR_W-1:0]     rd_word_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd) begin
         rd_word_ff <= mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.we) begin
            valid_ff[cmd.addr] <= 1'b1;
         end
         if (cmd.rd) begin
            rd_valid_ff <= valid_ff[cmd.addr];
         end
      end
   end

   assign rdata = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== hw/rtl/lmgf_seq.sv =====
// ----------------------------------------------------------------------------
// lmgf_seq
// Command sequencer: steps paint commands one pixel a cycle and maps a
// chain position to a frame pixel by repeated compare and subtract.
// ----------------------------------------------------------------------------
module lmgf_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lmgf_pkg::req_type      req_data,
   input  logic                   rsp_free,
   output lmgf_pkg::addr_op_type  addr_op,
   input  lmgf_pkg::addr_res_type addr_res,
   output lmgf_pkg::mem_cmd_type  mem_cmd,
   output lmgf_pkg::rsp_ctl_type  rsp_ctl
);
   import lmgf_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PAINT = 6'b000010,
      S_DIVP  = 6'b000100,
      S_DIVR  = 6'b001000,
      S_FETCH = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [STEP_W-1:0]    cursor_ff, cursor_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [INDEX_W-1:0]   rem_ff, rem_in;
   logic [BASEX_W-1:0]   pcol_ff, pcol_in;
   logic [BASEY_W-1:0]   prow_ff, prow_in;
   logic                 hit_ff, hit_in;
   logic [FONT_ROWS-1:0] font_col;
   logic                 paint_en;
   logic                 last_step;

   assign font_col = glyph_column(req_ff.glyph_code, cursor_ff[1:0]);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      cursor_in = cursor_ff;
      row_in    = row_ff;
      rem_in    = rem_ff;
      pcol_in   = pcol_ff;
      prow_in   = prow_ff;
      hit_in    = hit_ff;
      req_ready = 1'b0;
      paint_en  = 1'b1;
      last_step = 1'b1;
      addr_op   = '0;
      mem_cmd   = '0;
      rsp_ctl.load     = 1'b0;
      rsp_ctl.hit      = hit_ff;
      rsp_ctl.position = req_ff.chain_index;
      mem_cmd.addr  = addr_res.addr;
      mem_cmd.wdata = req_ff.paint_color;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in    = req_data;
               cursor_in = '0;
               row_in    = '0;
               priority if (req_data.opcode == OP_SET || req_data.opcode == OP_GLYPH ||
                            req_data.opcode == OP_HLINE || req_data.opcode == OP_VLINE) begin
                  state_in = S_PAINT;
               end else if (req_data.opcode == OP_READ) begin
                  rem_in   = req_data.chain_index;
                  pcol_in  = '0;
                  prow_in  = '0;
                  state_in = S_DIVP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAINT: begin
            addr_op.base_x = BASEX_W'(req_ff.pos_x);
            addr_op.base_y = BASEY_W'(req_ff.pos_y);
            unique case (req_ff.opcode)
               OP_GLYPH: begin
                  addr_op.off_x = cursor_ff;
                  addr_op.off_y = STEP_W'(row_ff);
                  paint_en      = font_col[row_ff];
                  last_step     = (cursor_ff == STEP_W'(GLYPH_COLS - 1)) &&
                                  (row_ff == ROW_W'(FONT_ROWS - 1));
               end
               OP_HLINE: begin
                  addr_op.off_x = cursor_ff;
                  last_step     = (cursor_ff == req_ff.line_length);
               end
               OP_VLINE: begin
                  addr_op.off_y = cursor_ff;
                  last_step     = (cursor_ff == req_ff.line_length);
               end
               default: begin
                  last_step = 1'b1;
               end
            endcase
            mem_cmd.we = paint_en && addr_res.hit;
            if (last_step) begin
               cursor_in = '0;
               row_in    = '0;
               state_in  = S_IDLE;
            end else if (req_ff.opcode == OP_GLYPH) begin
               if (row_ff == ROW_W'(FONT_ROWS - 1)) begin
                  row_in    = '0;
                  cursor_in = cursor_ff + STEP_W'(1);
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               cursor_in = cursor_ff + STEP_W'(1);
            end
         end
         S_DIVP: begin
            if ({1'b0, rem_ff} >= (INDEX_W+1)'(PER_PANEL)) begin
               rem_in  = rem_ff - INDEX_W'(PER_PANEL);
               pcol_in = pcol_ff + BASEX_W'(PANEL_SIDE);
            end else begin
               state_in = S_DIVR;
            end
         end
         S_DIVR: begin
            if ({1'b0, rem_ff} >= (INDEX_W+1)'(PANEL_SIDE)) begin
               rem_in  = rem_ff - INDEX_W'(PANEL_SIDE);
               prow_in = prow_ff + BASEY_W'(1);
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            addr_op.base_x = pcol_ff;
            addr_op.off_x  = STEP_W'(rem_ff);
            addr_op.base_y = prow_ff;
            mem_cmd.rd     = addr_res.hit;
            hit_in         = addr_res.hit;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_ctl.load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cursor_ff <= '0;
         row_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rem_ff  <= rem_in;
      pcol_ff <= pcol_in;
      prow_ff <= prow_in;
      hit_ff  <= hit_in;
   end

endmodule

// ===== hw/rtl/led_matrix_glyph_framebuffer.sv =====
// ----------------------------------------------------------------------------
// led_matrix_glyph_framebuffer
// 24x8 frame of 24-bit colors with pixel, glyph, line and read commands.
// ----------------------------------------------------------------------------
// One command word is taken when the block is idle and is then worked one
// pixel per cycle through a single coordinate/address unit and the one port
// of the frame memory. A glyph covers 3 columns of 5 rows, and an unused
// opcode is dropped while idle. A read walks the chain index down by panel
// and then by row, one compare and subtract a cycle, and then posts its
// word; the response register lets the next command start while that word
// waits. The frame reads dark after reset with no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_glyph_framebuffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lmgf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lmgf_pkg::rsp_type rsp_data
);
   import lmgf_pkg::*;

   addr_op_type        addr_op;
   addr_res_type       addr_res;
   mem_cmd_type        mem_cmd;
   rsp_ctl_type        rsp_ctl;
   logic [COLOR_W-1:0] store_rdata;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   lmgf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .addr_op   (addr_op),
      .addr_res  (addr_res),
      .mem_cmd   (mem_cmd),
      .rsp_ctl   (rsp_ctl)
   );

   lmgf_addr u_addr (
      .op  (addr_op),
      .res (addr_res)
   );

   lmgf_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (mem_cmd),
      .rdata (store_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_ctl.load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.read_color     = rsp_ctl.hit ? store_rdata : '0;
         rsp_in.read_position  = rsp_ctl.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== verif/tb_led_matrix_glyph_framebuffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_glyph_framebuffer
// Self-checking bench for the LED matrix glyph frame buffer. A frame model
// tracks every pixel, glyph and line command as it is accepted and queues
// the color each read must return. Response words are compared field by
// field in order. Directed corner cases come first, then random traffic
// under three sender/receiver idle mixes and a long response stall.
// ----------------------------------------------------------------------------
module tb_led_matrix_glyph_framebuffer;
   import lmgf_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int PHASE_ITEMS     = 350;
   localparam int RSP_HOLD_CYCLES = 1500;
   localparam int STALL_READS     = 40;
   localparam int GLYPH_CODES     = 12;

   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   // column bytes, bit k paints row pos_y+k
   localparam logic [7:0] GLYPH_FONT [GLYPH_CODES][GLYPH_COLS] = '{
      '{8'h1F, 8'h11, 8'h1F}, '{8'h00, 8'h00, 8'h1F}, '{8'h1D, 8'h15, 8'h17},
      '{8'h15, 8'h15, 8'h1F}, '{8'h07, 8'h04, 8'h1F}, '{8'h17, 8'h15, 8'h1D},
      '{8'h1F, 8'h15, 8'h1D}, '{8'h01, 8'h01, 8'h1F}, '{8'h1F, 8'h15, 8'h1F},
      '{8'h17, 8'h15, 8'h1F}, '{8'h00, 8'h0A, 8'h00}, '{8'h00, 8'h04, 8'h00}
   };

   class frame_predictor;
      logic [COLOR_W-1:0] pixels [FRAME_HEIGHT][FRAME_WIDTH];
      rsp_type            pending_reads [$];
      int                 mismatches;
      int                 reads_checked;

      function new();
         foreach (pixels[r, c]) pixels[r][c] = '0;
         mismatches    = 0;
         reads_checked = 0;
      endfunction

      function void paint(int x, int y, logic [COLOR_W-1:0] color);
         if (x < FRAME_WIDTH && y < FRAME_HEIGHT) pixels[y][x] = color;
      endfunction

      function void apply_command(req_type c);
         int      code;
         int      col;
         int      row;
         int      i;
         int      panel;
         int      rem;
         int      px;
         int      py;
         rsp_type word;
         case (c.opcode)
            OP_SET: paint(int'(c.pos_x), int'(c.pos_y), c.paint_color);
            OP_GLYPH: begin
               code = (c.glyph_code >= GLYPH_CODES) ? 0 : int'(c.glyph_code);
               for (col = 0; col < GLYPH_COLS; col++) begin
                  for (row = 0; row < 8; row++) begin
                     if (GLYPH_FONT[code][col][row])
                        paint(int'(c.pos_x) + col, int'(c.pos_y) + row, c.paint_color);
                  end
               end
            end
            OP_HLINE: begin
               for (i = 0; i <= int'(c.line_length); i++)
                  paint(int'(c.pos_x) + i, int'(c.pos_y), c.paint_color);
            end
            OP_VLINE: begin
               for (i = 0; i <= int'(c.line_length); i++)
                  paint(int'(c.pos_x), int'(c.pos_y) + i, c.paint_color);
            end
            OP_READ: begin
               panel = int'(c.chain_index) / PER_PANEL;
               rem   = int'(c.chain_index) % PER_PANEL;
               py    = rem / PANEL_SIDE;
               px    = panel * PANEL_SIDE + rem % PANEL_SIDE;
               word.read_color    = (px < FRAME_WIDTH && py < FRAME_HEIGHT) ?
                                    pixels[py][px] : '0;
               word.read_position = c.chain_index;
               pending_reads.push_back(word);
            end
            default: ;
         endcase
      endfunction

      function void check_read(rsp_type got);
         rsp_type want;
         if (pending_reads.size() == 0) begin
            $display("%0t: unexpected read word, color %06h position %0d",
                     $time, got.read_color, got.read_position);
            mismatches++;
            return;
         end
         want = pending_reads.pop_front();
         reads_checked++;
         if (got.read_color !== want.read_color) begin
            $display("%0t: read_color mismatch, expected %06h actual %06h",
                     $time, want.read_color, got.read_color);
            mismatches++;
         end
         if (got.read_position !== want.read_position) begin
            $display("%0t: read_position mismatch, expected %0d actual %0d",
                     $time, want.read_position, got.read_position);
            mismatches++;
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   req_type        req_data;
   logic           rsp_valid;
   logic           rsp_ready;
   rsp_type        rsp_data;

   frame_predictor frame_model;
   int             cycle_count;
   int             req_idle_pct;
   int             rsp_idle_pct;
   int             hold_request;
   int             commands_sent;

   led_matrix_glyph_framebuffer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** led_matrix_glyph_framebuffer: FAILED **");
      $finish;
   end

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) frame_model.check_read(rsp_data);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_command(input req_type c);
      req_data  <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      frame_model.apply_command(c);
      commands_sent++;
   endtask

   task automatic issue(input logic [2:0] op, input int x, input int y, input int len,
                        input int code, input logic [COLOR_W-1:0] color, input int idx);
      req_type c;
      c.opcode      = op;
      c.pos_x       = 6'(x);
      c.pos_y       = 4'(y);
      c.line_length = 6'(len);
      c.glyph_code  = 4'(code);
      c.paint_color = color;
      c.chain_index = 8'(idx);
      send_command(c);
   endtask

   task automatic maybe_gap();
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_reads_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_model.pending_reads.size() != 0) @(posedge clock);
   endtask

   function automatic req_type random_command();
      req_type c;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      c.opcode = OP_READ;
      else if (pick < 50) c.opcode = OP_SET;
      else if (pick < 68) c.opcode = OP_GLYPH;
      else if (pick < 79) c.opcode = OP_HLINE;
      else if (pick < 90) c.opcode = OP_VLINE;
      else                c.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      c.pos_x       = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 25)) : 6'($urandom);
      c.pos_y       = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom);
      c.line_length = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 23)) : 6'($urandom);
      c.glyph_code  = 4'($urandom);
      c.paint_color = 24'($urandom);
      c.chain_index = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 191)) :
                                                     8'($urandom);
      return c;
   endfunction

   task automatic run_random(input int target);
      int      counted;
      req_type c;
      counted = 0;
      while (counted < target) begin
         c = random_command();
         maybe_gap();
         send_command(c);
         counted++;
      end
   endtask

   initial begin : req_side
      req_type c;
      int      i;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      hold_request  = 0;
      commands_sent = 0;
      frame_model   = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue(OP_READ,   0,  0,  0,  0, 24'h000000,   0);
      issue(OP_SET,    0,  0,  0,  0, 24'hFFFFFF,   0);
      issue(OP_SET,   23,  7,  0,  0, 24'h000001,   0);
      issue(OP_SET,   24,  0,  0,  0, 24'h123456,   0);
      issue(OP_SET,    0,  8,  0,  0, 24'h654321,   0);
      issue(OP_SET,   63, 15, 63, 15, 24'hFFFFFF, 255);
      issue(OP_GLYPH,  0,  0,  0,  8, 24'hA5A5A5,   0);
      issue(OP_GLYPH, 21,  3,  0, 15, 24'h5A5A5A,   0);
      issue(OP_GLYPH, 22,  6,  0, 10, 24'h0F0F0F,   0);
      issue(OP_GLYPH, 63, 15,  0, 11, 24'hF0F0F0,   0);
      issue(OP_HLINE,  0,  7, 63,  0, 24'hFF0000,   0);
      issue(OP_VLINE, 23,  0, 63,  0, 24'h00FF00,   0);
      issue(OP_HLINE,  5,  2,  0,  0, 24'h0000FF,   0);
      issue(OP_VLINE, 10, 15,  5,  0, 24'hABCDEF,   0);
      issue(OP_SPARE_LO,  1, 1,  4,  3, 24'hFFFFFF, 10);
      issue(OP_SPARE_MID, 2, 2,  8,  7, 24'hFFFFFF, 20);
      issue(OP_SPARE_HI,  3, 3, 63, 15, 24'hFFFFFF, 30);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000,   0);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000,   7);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000,  63);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000,  64);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000, 191);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000, 192);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000, 255);
      issue(OP_READ,   0,  0,  0,  0, 24'h000000,  56);
      wait_reads_done();

      req_idle_pct = 35;
      rsp_idle_pct = 80;
      run_random(PHASE_ITEMS);
      wait_reads_done();

      req_idle_pct = 80;
      rsp_idle_pct = 35;
      run_random(PHASE_ITEMS);
      wait_reads_done();

      // stall responses while reads keep coming, so the input backs up
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = RSP_HOLD_CYCLES;
      for (i = 0; i < STALL_READS; i++) begin
         c        = random_command();
         c.opcode = OP_READ;
         send_command(c);
      end
      run_random(PHASE_ITEMS - STALL_READS);

      wait_reads_done();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands over pixel, glyph, line, read and spare opcodes; %0d reads",
               commands_sent, frame_model.reads_checked);
      $display("checked with edge clipping, off-chain reads, idle mixes and a %0d-cycle stall",
               RSP_HOLD_CYCLES);
      if (frame_model.mismatches == 0 && frame_model.pending_reads.size() == 0) begin
         $display("** led_matrix_glyph_framebuffer: PASSED **");
      end else begin
         $display("** led_matrix_glyph_framebuffer: FAILED **");
      end
      $finish;
   end

endmodule
